@@ src/lpbd_pkg.sv @@
// Shared types and constants for the length-prefixed buffer deframer.
package lpbd_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned WordW   = 32;
    localparam int unsigned IndexW  = 8;
    localparam int unsigned LaneW   = 2;
    localparam int unsigned PosW    = 3;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             begin_message;
    } in_item_t;

    typedef struct packed {
        logic              result_kind;
        logic [IndexW-1:0] buffer_index;
        logic [WordW-1:0]  result_value;
        logic [WordW-1:0]  byte_offset;
        logic              last_of_buffer;
    } result_t;

endpackage

@@ src/lpbd_in_stage.sv @@
// Input register stage: holds one accepted item until the decoder takes it.
module lpbd_in_stage
    import lpbd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    // The stage refills whenever it is empty or its item moves on this cycle.
    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ src/lpbd_core.sv @@
// Deframing state and the per-byte decision logic.
module lpbd_core
    import lpbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  in_item_t          item,
    input  logic [IndexW-1:0] buffer_count,
    output logic              res_valid,
    output result_t           res
);

    logic [WordW-1:0]  size_word_reg,      size_word_next;
    logic [LaneW-1:0]  size_seen_reg,      size_seen_next;
    logic [WordW-1:0]  data_offset_reg,    data_offset_next;
    logic [IndexW-1:0] cur_buffer_reg,     cur_buffer_next;
    logic [PosW-1:0]   pos_reg,            pos_next;

    logic [WordW-1:0]  eff_word;
    logic [LaneW-1:0]  eff_seen;
    logic [WordW-1:0]  eff_offset;
    logic [IndexW-1:0] eff_buffer;
    logic [PosW-1:0]   eff_pos;
    logic [WordW-1:0]  lane_word;
    logic [WordW-1:0]  offset_inc;
    logic              is_last;

    always_comb
    begin
        // A message start clears the state before this byte is decoded.
        eff_word   = item.begin_message ? '0 : size_word_reg;
        eff_seen   = item.begin_message ? '0 : size_seen_reg;
        eff_offset = item.begin_message ? '0 : data_offset_reg;
        eff_buffer = item.begin_message ? '0 : cur_buffer_reg;
        eff_pos    = item.begin_message ? '0 : pos_reg;

        lane_word = eff_word;
        case (eff_seen)
            2'd0:    lane_word[7:0]   = item.data_byte;
            2'd1:    lane_word[15:8]  = item.data_byte;
            2'd2:    lane_word[23:16] = item.data_byte;
            default: lane_word[31:24] = item.data_byte;
        endcase

        offset_inc = eff_offset + WordW'(1);
        is_last    = (offset_inc == eff_word);

        size_word_next   = eff_word;
        size_seen_next   = eff_seen;
        data_offset_next = eff_offset;
        cur_buffer_next  = eff_buffer;
        pos_next         = eff_pos;

        res_valid          = 1'b0;
        res.result_kind    = KIND_DATA;
        res.buffer_index   = eff_buffer;
        res.result_value   = {{(WordW-ByteW){1'b0}}, item.data_byte};
        res.byte_offset    = eff_offset;
        res.last_of_buffer = is_last;

        if (eff_buffer >= buffer_count)
        begin
            // Past the final buffer: the byte is dropped, nothing advances.
        end
        else if (eff_word == '0 || eff_seen != '0)
        begin
            size_word_next = lane_word;
            size_seen_next = eff_seen + LaneW'(1);
            pos_next       = eff_pos + PosW'(1);
            if (size_seen_next == '0 && lane_word != '0)
            begin
                res_valid          = 1'b1;
                res.result_kind    = KIND_HEADER;
                res.result_value   = lane_word;
                res.byte_offset    = '0;
                res.last_of_buffer = 1'b0;
            end
        end
        else if (eff_offset == '0 && eff_pos != '0)
        begin
            // Alignment pad ahead of the first data byte.
            pos_next = eff_pos + PosW'(1);
        end
        else
        begin
            res_valid = 1'b1;
            pos_next  = eff_pos + PosW'(1);
            if (is_last)
            begin
                size_word_next   = '0;
                data_offset_next = '0;
                cur_buffer_next  = eff_buffer + IndexW'(1);
            end
            else
            begin
                data_offset_next = offset_inc;
            end
        end

        res_valid = res_valid && fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_word_reg   <= '0;
            size_seen_reg   <= '0;
            data_offset_reg <= '0;
            cur_buffer_reg  <= '0;
            pos_reg         <= '0;
        end
        else if (fire)
        begin
            size_word_reg   <= size_word_next;
            size_seen_reg   <= size_seen_next;
            data_offset_reg <= data_offset_next;
            cur_buffer_reg  <= cur_buffer_next;
            pos_reg         <= pos_next;
        end
    end

`ifndef ASSERT_OFF
    a_header_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.result_kind == KIND_HEADER |-> res.result_value != '0)
        else $error("header item carries a zero size");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.result_kind == KIND_DATA && res.last_of_buffer
        |=> size_word_reg == '0 && data_offset_reg == '0)
        else $error("buffer state not cleared after its last byte");

    a_no_data_mid_size: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !item.begin_message && size_seen_reg != '0
        |-> !(res_valid && res.result_kind == KIND_DATA))
        else $error("data item produced while a size word is half read");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.buffer_index < buffer_count)
        else $error("result for a buffer beyond the configured count");
`endif

endmodule

@@ src/lpbd_out_stage.sv @@
// Output register: holds one result until the consumer takes it.
module lpbd_out_stage
    import lpbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    can_take,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_take   = !valid_reg || !out_stall;
    assign valid_next = load ? 1'b1 : (out_stall ? valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

@@ src/length_prefixed_buffer_deframer_top.sv @@
// Top level of the length-prefixed buffer deframer.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   input    | in_valid / in_stall     | data_byte, begin_message
//   result   | out_valid / out_stall   | result_kind, buffer_index, result_value,
//            |                         | byte_offset, last_of_buffer
//   config   | cfg_valid / cfg_ready   | buffer_count
//
// One item is accepted per cycle when nothing stalls. An item is decoded while it sits in
// the input register and its result is loaded into the output register once that register
// can take it, so a result passes the input and output registers in turn; throughput is
// set by the single decode step, one item per cycle when nothing stalls.
// Reset clears all deframing state and sets buffer_count to zero. When the output
// register is full and stalled, an item in the input register stays there and in_stall
// is high.
module length_prefixed_buffer_deframer_top
    import lpbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [ByteW-1:0]  data_byte,
    input  logic              begin_message,

    output logic              out_valid,
    input  logic              out_stall,
    output logic              result_kind,
    output logic [IndexW-1:0] buffer_index,
    output logic [WordW-1:0]  result_value,
    output logic [WordW-1:0]  byte_offset,
    output logic              last_of_buffer,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IndexW-1:0] buffer_count
);

    logic [IndexW-1:0] buffer_count_reg;
    in_item_t          in_item;
    in_item_t          item;
    logic              item_valid;
    logic              can_take;
    logic              fire;
    logic              res_valid;
    result_t           res;
    result_t           out_res;

    // The configuration register is always writable, so the user must write it only while idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            buffer_count_reg <= buffer_count;
        end
    end

    assign in_item.data_byte     = data_byte;
    assign in_item.begin_message = begin_message;

    // The held item is decoded as soon as the output register can take a result,
    // whether or not this item actually produces one.
    assign fire = item_valid && can_take;

    lpbd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    lpbd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .item         (item),
        .buffer_count (buffer_count_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    lpbd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .can_take  (can_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign result_kind    = out_res.result_kind;
    assign buffer_index   = out_res.buffer_index;
    assign result_value   = out_res.result_value;
    assign byte_offset    = out_res.byte_offset;
    assign last_of_buffer = out_res.last_of_buffer;

endmodule

@@ tb/tb_length_prefixed_buffer_deframer_top.sv @@
// Testbench for the length-prefixed buffer deframer: directed table, then random messages.
module tb_length_prefixed_buffer_deframer_top;
    import lpbd_pkg::*;

    // Run limits. A result passes only the input and output registers after its item, so
    // SETTLE_CYCLES idle cycles are enough to be sure that nothing is still in flight.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD     = 200;
    localparam int unsigned CYCLE_LIMIT   = 100000;
    localparam int unsigned REPORT_LIMIT  = 10;

    // Where the expected result of an item comes from: the predictor, nothing at
    // all, or a value written into the directed table by hand.
    typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_KNOWN} check_src_t;

    typedef struct {
        logic [ByteW-1:0] data_byte;
        logic             begin_message;
        check_src_t       src;
        result_t          known;
    } stim_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [ByteW-1:0]  data_byte;
    logic              begin_message;
    logic              out_valid;
    logic              out_stall;
    logic              result_kind;
    logic [IndexW-1:0] buffer_index;
    logic [WordW-1:0]  result_value;
    logic [WordW-1:0]  byte_offset;
    logic              last_of_buffer;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IndexW-1:0] buffer_count;

    // Side information that travels with the item on the input channel.
    check_src_t        drv_src;
    result_t           drv_known;

    // Predictor state, a copy of what the block keeps, plus its register.
    logic [WordW-1:0]  size_acc      = '0;
    logic [LaneW-1:0]  lane_count    = '0;
    logic [WordW-1:0]  data_pos      = '0;
    logic [IndexW-1:0] buf_sel       = '0;
    logic [PosW-1:0]   align_pos     = '0;
    logic [IndexW-1:0] count_setting = '0;

    result_t           results_due[$];
    stim_t             directed_rows[$];
    stim_t             stim_q[$];

    int unsigned       mismatches  = 0;
    int unsigned       cycle_count = 0;
    int unsigned       sent        = 0;
    bit                tx_idle_on  = 1'b1;
    bit                long_hold_req = 1'b0;

    length_prefixed_buffer_deframer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .begin_message (begin_message),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .buffer_index  (buffer_index),
        .result_value  (result_value),
        .byte_offset   (byte_offset),
        .last_of_buffer(last_of_buffer),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .buffer_count  (buffer_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decodes one byte of the message stream and updates the predictor state.
    // Returns 1 when the byte produces a header or a data result.
    function automatic bit deframe_step(input logic [ByteW-1:0] d, input logic start,
                                        output result_t r);
        r = '0;
        if (start)
        begin
            size_acc   = '0;
            lane_count = '0;
            data_pos   = '0;
            buf_sel    = '0;
            align_pos  = '0;
        end
        // Once every buffer has been seen, bytes are dropped without touching state.
        if (buf_sel >= count_setting)
            return 1'b0;
        // A size word is collected whenever no nonzero size is pending.
        if (size_acc == '0 || lane_count != '0)
        begin
            size_acc[{lane_count, 3'b000} +: 8] = d;
            lane_count = lane_count + 1'b1;
            align_pos  = align_pos + 1'b1;
            if (lane_count == '0 && size_acc != '0)
            begin
                r.result_kind  = KIND_HEADER;
                r.buffer_index = buf_sel;
                r.result_value = size_acc;
                return 1'b1;
            end
            return 1'b0;
        end
        // Padding only comes before the first data byte of a buffer.
        if (data_pos == '0 && align_pos != '0)
        begin
            align_pos = align_pos + 1'b1;
            return 1'b0;
        end
        r.result_kind    = KIND_DATA;
        r.buffer_index   = buf_sel;
        r.result_value   = {24'd0, d};
        r.byte_offset    = data_pos;
        r.last_of_buffer = (data_pos + 32'd1) == size_acc;
        if (r.last_of_buffer)
        begin
            size_acc = '0;
            data_pos = '0;
            buf_sel  = buf_sel + 1'b1;
        end
        else
        begin
            data_pos = data_pos + 32'd1;
        end
        align_pos = align_pos + 1'b1;
        return 1'b1;
    endfunction

    // One row of the directed table.
    function automatic void dir_row(input logic [ByteW-1:0] d, input logic start,
                                    input check_src_t src, input logic kind,
                                    input logic [IndexW-1:0] idx, input logic [WordW-1:0] val,
                                    input logic [WordW-1:0] off, input logic last);
        stim_t row;
        row.data_byte     = d;
        row.begin_message = start;
        row.src           = src;
        row.known         = '{result_kind: kind, buffer_index: idx, result_value: val,
                              byte_offset: off, last_of_buffer: last};
        directed_rows.push_back(row);
    endfunction

    function automatic stim_t data_item(input logic [ByteW-1:0] d);
        stim_t it;
        it.data_byte     = d;
        it.begin_message = 1'b0;
        it.src           = CHK_PREDICT;
        it.known         = '0;
        return it;
    endfunction

    // Random bytes with an occasional begin flag, none of them shaped as a message.
    function automatic void add_noise();
        int unsigned n;
        int unsigned k;
        stim_t       it;
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
        begin
            it = data_item(8'($urandom));
            it.begin_message = ($urandom_range(0, 7) == 0);
            stim_q.push_back(it);
        end
    endfunction

    // A well-formed message with random content: size words in little-endian order,
    // padding up to the next multiple of eight, then the data bytes. Some messages
    // carry a zero size word first, a huge size that never completes, trailing bytes
    // or a cut-off tail.
    function automatic void add_message(input int unsigned bc);
        stim_t       msg[$];
        int unsigned nbuf;
        int unsigned pos;
        int unsigned size;
        int unsigned pads;
        int unsigned ndata;
        int unsigned pick;
        int unsigned keep;
        int unsigned b;
        int unsigned k;
        nbuf = (bc <= 8) ? bc : $urandom_range(1, 6);
        if (nbuf == 0)
            nbuf = 1;
        pos = 0;
        for (b = 0; b < nbuf; b++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                for (k = 0; k < 4; k++)
                    msg.push_back(data_item(8'h00));
                pos += 4;
            end
            pick = $urandom_range(0, 99);
            if (pick < 85)
                size = $urandom_range(1, 12);
            else if (pick < 95)
                size = $urandom_range(13, 64);
            else
                size = $urandom | 32'h0100_0000;
            for (k = 0; k < 4; k++)
                msg.push_back(data_item(size[8*k +: 8]));
            pos += 4;
            pads = (8 - pos % 8) % 8;
            for (k = 0; k < pads; k++)
                msg.push_back(data_item(8'($urandom)));
            pos += pads;
            ndata = (size > 64) ? $urandom_range(0, 16) : size;
            for (k = 0; k < ndata; k++)
                msg.push_back(data_item(8'($urandom)));
            pos += ndata;
            if (size > 64)
                break;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            pick = $urandom_range(1, 4);
            for (k = 0; k < pick; k++)
                msg.push_back(data_item(8'($urandom)));
        end
        if ($urandom_range(0, 7) == 0 && msg.size() > 1)
        begin
            keep = $urandom_range(1, msg.size() - 1);
            while (msg.size() > keep)
                msg.delete(msg.size() - 1);
        end
        // Most messages start fresh; the rest run on from whatever state is left.
        if ($urandom_range(0, 9) != 0)
            msg[0].begin_message = 1'b1;
        for (k = 0; k < msg.size(); k++)
            stim_q.push_back(msg[k]);
    endfunction

    // Offers one item after a random gap and waits until the block takes it.
    task automatic send_item(input stim_t it);
        int unsigned gap;
        if (sent % 64 == 0)
            tx_idle_on = ($urandom_range(0, 3) != 0);
        gap = tx_idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= it.data_byte;
        begin_message <= it.begin_message;
        drv_src       <= it.src;
        drv_known     <= it.known;
        @(posedge clk);
        while (!(in_valid && !in_stall))
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // Waits until every expected result has come out, then lets the pipeline settle
    // so that items without a result are through as well.
    task automatic drain();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_count(input logic [IndexW-1:0] value);
        cfg_valid    <= 1'b1;
        buffer_count <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random phase at a fixed buffer count. The block is idle on entry.
    task automatic run_phase(input logic [IndexW-1:0] bc, input int unsigned items,
                             input bit hold);
        write_count(bc);
        if (hold)
            long_hold_req = 1'b1;
        while (stim_q.size() < items)
        begin
            if (bc == '0 || $urandom_range(0, 19) == 0)
                add_noise();
            else
                add_message(bc);
        end
        while (stim_q.size() != 0)
            send_item(stim_q.pop_front());
        drain();
    endtask

    // Checker. Every accepted item steps the predictor; every accepted result is
    // compared against the oldest outstanding expectation.
    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        result_t pred;
        bit      produced;
        bit      bad;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                count_setting = buffer_count;
            if (in_valid && !in_stall)
            begin
                produced = deframe_step(data_byte, begin_message, pred);
                case (drv_src)
                    CHK_PREDICT:
                        if (produced)
                            results_due.push_back(pred);
                    CHK_KNOWN:
                        results_due.push_back(drv_known);
                    default:
                        ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got.result_kind    = result_kind;
                got.buffer_index   = buffer_index;
                got.result_value   = result_value;
                got.byte_offset    = byte_offset;
                got.last_of_buffer = last_of_buffer;
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: kind %0d buf %0d value %h offset %0d last %0d",
                                 got.result_kind, got.buffer_index, got.result_value,
                                 got.byte_offset, got.last_of_buffer);
                end
                else
                begin
                    want = results_due.pop_front();
                    bad = (got.result_kind !== want.result_kind)
                       || (got.buffer_index !== want.buffer_index)
                       || (got.result_value !== want.result_value)
                       || (got.byte_offset !== want.byte_offset)
                       || (got.last_of_buffer !== want.last_of_buffer);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $write("mismatch: expected kind %0d buf %0d value %h ",
                                   want.result_kind, want.buffer_index, want.result_value);
                            $write("offset %0d last %0d, got kind %0d buf %0d ",
                                   want.byte_offset, want.last_of_buffer,
                                   got.result_kind, got.buffer_index);
                            $display("value %h offset %0d last %0d",
                                     got.result_value, got.byte_offset, got.last_of_buffer);
                        end
                    end
                end
            end
        end
    end

    // Watchdog. A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side. Before each result the receiver stalls for a random number of
    // cycles; every 64 results it decides whether to stall at all for a while. When
    // asked, it holds off for a long stretch so the block backs up into its input.
    initial
    begin : receiver
        int unsigned wait_cycles;
        int unsigned served;
        bit          rx_idle_on;
        out_stall  = 1'b0;
        served     = 0;
        rx_idle_on = 1'b1;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (served % 64 == 0)
                rx_idle_on = ($urandom_range(0, 3) != 0);
            wait_cycles = rx_idle_on ? $urandom_range(0, 6) : 0;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                wait_cycles   = LONG_HOLD;
            end
            if (wait_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
            served++;
            @(negedge clk);
        end
    end

    // Main sequence: reset, the directed table, then random phases at several
    // buffer counts, among them zero and the largest value.
    initial
    begin : sequencer
        int i;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = '0;
        begin_message = 1'b0;
        cfg_valid     = 1'b0;
        buffer_count  = '0;
        drv_src       = CHK_NONE;
        drv_known     = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The buffer count is still zero after reset, so the first two bytes are
        // dropped, the begin flag included.
        dir_row(8'h5A, 1'b0, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'hA5, 1'b1, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        // Buffer 0 has size 2. Four pad bytes bring the position up to eight.
        dir_row(8'h02, 1'b1, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'h00, 1'b0, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'h00, 1'b0, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'h00, 1'b0, CHK_KNOWN, KIND_HEADER, 8'd0, 32'd2, 32'd0, 1'b0);
        dir_row(8'hAA, 1'b0, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'h55, 1'b0, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'hFF, 1'b0, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'h00, 1'b0, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'hFF, 1'b0, CHK_KNOWN, KIND_DATA,   8'd0, 32'hFF, 32'd0, 1'b0);
        dir_row(8'h00, 1'b0, CHK_KNOWN, KIND_DATA,   8'd0, 32'd0, 32'd1, 1'b1);
        // Buffer 1 first gets a zero size word, which is skipped, and then the
        // largest possible size.
        dir_row(8'h00, 1'b0, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'h00, 1'b0, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'h00, 1'b0, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'h00, 1'b0, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'hFF, 1'b0, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'hFF, 1'b0, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'hFF, 1'b0, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'hFF, 1'b0, CHK_KNOWN, KIND_HEADER, 8'd1, 32'hFFFF_FFFF, 32'd0, 1'b0);
        // The position is not aligned, so the next byte is a pad byte.
        dir_row(8'h81, 1'b0, CHK_NONE,  KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        // A new message starts in the middle of the huge buffer.
        dir_row(8'h01, 1'b1, CHK_PREDICT, KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'h00, 1'b0, CHK_PREDICT, KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'h80, 1'b0, CHK_PREDICT, KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);
        dir_row(8'h00, 1'b0, CHK_PREDICT, KIND_HEADER, 8'd0, 32'd0, 32'd0, 1'b0);

        for (i = 0; i < directed_rows.size(); i++)
        begin
            // The largest buffer count goes in once the reset-state rows are through.
            if (i == 2)
            begin
                drain();
                write_count(8'd255);
            end
            send_item(directed_rows[i]);
        end
        drain();

        // Random phases. The second one carries the long receiver hold-off. The last
        // one may start mid-message, so the new count applies to a message in flight.
        run_phase(8'd1, 150, 1'b0);
        run_phase(8'd4, 300, 1'b1);
        run_phase(8'd255, 250, 1'b0);
        run_phase(8'd0, 30, 1'b0);
        run_phase(8'($urandom_range(2, 8)), 300, 1'b0);
        run_phase(8'd3, 200, 1'b0);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
src/lpbd_pkg.sv
src/lpbd_in_stage.sv
src/lpbd_core.sv
src/lpbd_out_stage.sv
src/length_prefixed_buffer_deframer_top.sv
tb/tb_length_prefixed_buffer_deframer_top.sv
